@@ src/assert_macros.svh @@
// Assertion helpers for the checker file lin_fr_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LFR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lin_frame_receiver: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LFR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lin_frame_receiver: check failed");

`endif

@@ src/lin_fr_pkg.sv @@
`default_nettype none
package lin_fr_pkg;

	// input mode codes
	localparam logic [1:0] MODE_BYTE  = 2'd0;
	localparam logic [1:0] MODE_BREAK = 2'd1;
	localparam logic [1:0] MODE_ARM   = 2'd2;

	// result kinds
	localparam logic KIND_FRAME = 1'b0;
	localparam logic KIND_RESP  = 1'b1;

	localparam logic [7:0] SYNC_BYTE   = 8'h55;
	localparam logic [7:0] CK_SEED     = 8'hFF;
	localparam logic [5:0] ID_LEN4_MIN = 6'h20;
	localparam logic [5:0] ID_LEN8_MIN = 6'h30;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		EV_BYTE,
		EV_BREAK,
		EV_ARM
	} ev_kind_t;

	// classified word passed from front to back
	typedef struct packed {
		ev_kind_t    kind;
		logic [7:0]  data;
	} ev_t;

	typedef enum logic [1:0] {
		PH_BREAK,
		PH_SYNC,
		PH_PID,
		PH_DATA
	} phase_t;

	function automatic logic [3:0] len_of_id(input logic [5:0] id);
		logic [3:0] len;
		if (id < ID_LEN4_MIN)
			len = 4'd2;
		else if (id < ID_LEN8_MIN)
			len = 4'd4;
		else
			len = 4'd8;
		return len;
	endfunction

endpackage
`default_nettype wire

@@ src/lin_fr_if.sv @@
`default_nettype none
// Input channel: UART events.
interface lin_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [7:0]  rx_byte;

	modport source (output valid, output mode, output rx_byte, input ready);
	modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

// Output channel: frames and response requests.
interface lin_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [5:0]  frame_id;
	logic [3:0]  data_length;
	logic [63:0] frame_data;
	logic        checksum_ok;

	modport source (output valid, output kind, output frame_id, output data_length,
		output frame_data, output checksum_ok, input ready);
	modport sink   (input valid, input kind, input frame_id, input data_length,
		input frame_data, input checksum_ok, output ready);
endinterface

// Configuration write channel: response_id.
interface lin_cfg_if;
	logic        valid;
	logic        ready;
	logic [5:0]  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ src/lin_fr_front.sv @@
`default_nettype none
module lin_fr_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	lin_in_if.sink                 in_ch,
	output lin_fr_pkg::ev_t        ev,
	output logic                   ev_valid,
	input  wire logic              ev_ready
);

	lin_fr_pkg::ev_t ev_s1;
	logic            vld_s1;
	logic            take;
	logic            keep;
	lin_fr_pkg::ev_t ev_n;

	assign in_ch.ready = !vld_s1 || ev_ready;
	assign take        = in_ch.valid && in_ch.ready;

	// classify; unused mode code is accepted and dropped here
	always_comb begin
		ev_n.data = in_ch.rx_byte;
		ev_n.kind = lin_fr_pkg::EV_BYTE;
		keep      = 1'b1;
		case (in_ch.mode)
			lin_fr_pkg::MODE_BYTE:  ev_n.kind = lin_fr_pkg::EV_BYTE;
			lin_fr_pkg::MODE_BREAK: ev_n.kind = lin_fr_pkg::EV_BREAK;
			lin_fr_pkg::MODE_ARM:   ev_n.kind = lin_fr_pkg::EV_ARM;
			default:                keep      = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= keep;
		end else if (ev_ready) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ev_s1 <= ev_n;
		end
	end

	assign ev       = ev_s1;
	assign ev_valid = vld_s1;

endmodule
`default_nettype wire

@@ src/lin_fr_queue.sv @@
`default_nettype none
module lin_fr_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lin_fr_pkg::ev_t   push_ev,
	input  wire logic              push_valid,
	output logic                   push_ready,
	output lin_fr_pkg::ev_t        pop_ev,
	output logic                   pop_valid,
	input  wire logic              pop_ready
);

	lin_fr_pkg::ev_t                 mem_q [lin_fr_pkg::QDEPTH];
	logic [lin_fr_pkg::QPTR_W-1:0]   wr_q;
	logic [lin_fr_pkg::QPTR_W-1:0]   rd_q;
	logic [lin_fr_pkg::QCNT_W-1:0]   cnt_q;
	logic                            push;
	logic                            pop;

	assign push_ready = cnt_q != lin_fr_pkg::QCNT_W'(lin_fr_pkg::QDEPTH);
	assign pop_valid  = cnt_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_ev     = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == lin_fr_pkg::QPTR_W'(lin_fr_pkg::QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == lin_fr_pkg::QPTR_W'(lin_fr_pkg::QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_ev;
		end
	end

endmodule
`default_nettype wire

@@ src/lin_fr_back.sv @@
`default_nettype none
module lin_fr_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lin_fr_pkg::ev_t   ev,
	input  wire logic              ev_valid,
	output logic                   ev_ready,
	lin_cfg_if.sink                cfg,
	lin_out_if.source              out_ch
);

	lin_fr_pkg::phase_t phase_q, phase_d;
	logic [5:0]   id_q, id_d;
	logic [3:0]   len_q, len_d;
	logic [3:0]   cnt_q, cnt_d;
	logic [7:0]   ck_q, ck_d;
	logic [63:0]  data_q, data_d;
	logic         armed_q, armed_d;
	logic [5:0]   resp_id_q;

	logic         out_vld_q, out_vld_d;
	logic         kind_q, kind_d;
	logic [5:0]   oid_q, oid_d;
	logic [3:0]   olen_q, olen_d;
	logic [63:0]  odata_q, odata_d;
	logic         ok_q, ok_d;
	logic         load;
	logic         pop;
	logic [5:0]   id_n;

	// a word is taken only when the result register has room for its result
	assign ev_ready  = !out_vld_q || out_ch.ready;
	assign pop       = ev_valid && ev_ready;
	assign cfg.ready = 1'b1;
	assign id_n      = ev.data[5:0];

	always_comb begin
		phase_d = phase_q;
		id_d    = id_q;
		len_d   = len_q;
		cnt_d   = cnt_q;
		ck_d    = ck_q;
		data_d  = data_q;
		armed_d = armed_q;
		load    = 1'b0;
		kind_d  = lin_fr_pkg::KIND_FRAME;
		oid_d   = id_q;
		olen_d  = len_q;
		odata_d = data_q;
		ok_d    = 1'b0;
		if (pop) begin
			case (ev.kind)
				lin_fr_pkg::EV_BREAK: phase_d = lin_fr_pkg::PH_SYNC;
				lin_fr_pkg::EV_ARM:   armed_d = 1'b1;
				lin_fr_pkg::EV_BYTE: begin
					case (phase_q)
						lin_fr_pkg::PH_SYNC: begin
							phase_d = (ev.data == lin_fr_pkg::SYNC_BYTE) ?
								lin_fr_pkg::PH_PID : lin_fr_pkg::PH_BREAK;
						end
						lin_fr_pkg::PH_PID: begin
							id_d  = id_n;
							len_d = lin_fr_pkg::len_of_id(id_n);
							if (armed_q && id_n == resp_id_q) begin
								armed_d = 1'b0;
								phase_d = lin_fr_pkg::PH_BREAK;
								load    = 1'b1;
								kind_d  = lin_fr_pkg::KIND_RESP;
								oid_d   = id_n;
								olen_d  = lin_fr_pkg::len_of_id(id_n);
								odata_d = '0;
							end else begin
								phase_d = lin_fr_pkg::PH_DATA;
								cnt_d   = '0;
								ck_d    = lin_fr_pkg::CK_SEED;
								data_d  = '0;
							end
						end
						lin_fr_pkg::PH_DATA: begin
							if (cnt_q < len_q) begin
								ck_d = ck_q ^ ev.data;
								for (int i = 0; i < 8; i++) begin
									if (cnt_q[2:0] == 3'(i))
										data_d[8*i +: 8] = data_q[8*i +: 8] | ev.data;
								end
								cnt_d = cnt_q + 4'd1;
							end else begin
								// checksum byte closes the frame
								phase_d = lin_fr_pkg::PH_BREAK;
								load    = 1'b1;
								ok_d    = ck_q == ev.data;
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
		out_vld_d = load ? 1'b1 : (out_ch.ready ? 1'b0 : out_vld_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= lin_fr_pkg::PH_BREAK;
			id_q      <= '0;
			len_q     <= '0;
			cnt_q     <= '0;
			ck_q      <= lin_fr_pkg::CK_SEED;
			data_q    <= '0;
			armed_q   <= 1'b0;
			resp_id_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			id_q      <= id_d;
			len_q     <= len_d;
			cnt_q     <= cnt_d;
			ck_q      <= ck_d;
			data_q    <= data_d;
			armed_q   <= armed_d;
			out_vld_q <= out_vld_d;
			if (cfg.valid)
				resp_id_q <= cfg.data;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q  <= kind_d;
			oid_q   <= oid_d;
			olen_q  <= olen_d;
			odata_q <= odata_d;
			ok_q    <= ok_d;
		end
	end

	assign out_ch.valid       = out_vld_q;
	assign out_ch.kind        = kind_q;
	assign out_ch.frame_id    = oid_q;
	assign out_ch.data_length = olen_q;
	assign out_ch.frame_data  = odata_q;
	assign out_ch.checksum_ok = ok_q;

endmodule
`default_nettype wire

@@ src/lin_frame_receiver.sv @@
// channel  dir  payload                                           handshake
// in_ch    in   mode[1:0], rx_byte[7:0]                           valid/ready
// out_ch   out  kind, frame_id[5:0], data_length[3:0],            valid/ready
//               frame_data[63:0], checksum_ok
// cfg      in   data[5:0] (response_id)                           valid/ready
//
// One word per cycle sustained while out_ch takes results. A word passes the
// front register, a two-entry queue and the frame state machine; out_ch.valid
// rises when the word that closes the result reaches the result register.
// Reset (arst_n low) clears the state machine, queue and response_id at once.
// A stalled out_ch holds the result register; the back stops popping, and
// in_ch keeps taking words until the queue and front register are full.
// cfg is always ready.
`default_nettype none
module lin_frame_receiver (
	input  wire logic  clk,
	input  wire logic  arst_n,
	lin_in_if.sink     in_ch,
	lin_out_if.source  out_ch,
	lin_cfg_if.sink    cfg
);

	lin_fr_pkg::ev_t front_ev;
	logic            front_valid;
	logic            front_ready;
	lin_fr_pkg::ev_t q_ev;
	logic            q_valid;
	logic            q_ready;

	lin_fr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.ev       (front_ev),
		.ev_valid (front_valid),
		.ev_ready (front_ready)
	);

	lin_fr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_ev    (front_ev),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.pop_ev     (q_ev),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready)
	);

	lin_fr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.ev       (q_ev),
		.ev_valid (q_valid),
		.ev_ready (q_ready),
		.cfg      (cfg),
		.out_ch   (out_ch)
	);

endmodule
`default_nettype wire

@@ src/lin_fr_chk.sv @@
`default_nettype none
`include "assert_macros.svh"
module lin_fr_chk (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic        kind,
	input  wire logic [5:0]  frame_id,
	input  wire logic [3:0]  data_length,
	input  wire logic [63:0] frame_data,
	input  wire logic        checksum_ok
);

	`LFR_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)

	`LFR_ASSERT_IMP(a_len_short, clk, arst_n, out_valid && frame_id < 6'h20, data_length == 4'd2)

	`LFR_ASSERT_IMP(a_len_mid, clk, arst_n, out_valid && frame_id >= 6'h20 && frame_id < 6'h30, data_length == 4'd4)

	`LFR_ASSERT_IMP(a_resp_empty, clk, arst_n, out_valid && kind, frame_data == 64'd0 && !checksum_ok)

endmodule

bind lin_frame_receiver lin_fr_chk u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.kind        (out_ch.kind),
	.frame_id    (out_ch.frame_id),
	.data_length (out_ch.data_length),
	.frame_data  (out_ch.frame_data),
	.checksum_ok (out_ch.checksum_ok)
);
`default_nettype wire
